[rtl/core/pvbp_pkg.sv]
// Shared types, constants and varicode lookup for the PSK31 varicode byte packer.
package pvbp_pkg;

  localparam int unsigned ByteCountBits = 13;
  localparam int unsigned CmdDepth      = 2;
  localparam int unsigned MaxTxWidth    = 16;
  localparam int unsigned PadWidth      = 14;
  localparam int unsigned SegWidth      = 12;
  localparam int unsigned SegLenWidth   = 4;

  localparam logic [6:0]          NewlineChar = 7'd10;
  // newline varicode followed by its two zero separator bits
  localparam logic [SegWidth-1:0] NewlineSeg  = 12'h074;
  localparam logic [SegLenWidth-1:0] NewlineLen = 4'd7;

  typedef struct packed {
    logic [6:0] character;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          byte_out;
    logic                burst_start;
    logic                burst_end;
    logic [PadWidth-1:0] pad_bytes;
  } out_item_t;

  // One accepted character, classified into the bit segments it adds to the stream.
  typedef struct packed {
    logic                   start;
    logic                   c0_vld;
    logic [SegWidth-1:0]    c0_seg;
    logic [SegLenWidth-1:0] c0_len;
    logic                   c1_vld;
    logic [SegWidth-1:0]    c1_seg;
    logic [SegLenWidth-1:0] c1_len;
    logic                   close;
    logic [PadWidth-1:0]    lim;
  } cmd_t;

  localparam logic [9:0] VariTab [128] = '{
    10'h2AB, 10'h2DB, 10'h2ED, 10'h377, 10'h2EB, 10'h35F, 10'h2EF, 10'h2FD,
    10'h2FF, 10'h0EF, 10'h01D, 10'h36F, 10'h2DD, 10'h01F, 10'h375, 10'h3AB,
    10'h2F7, 10'h2F5, 10'h3AD, 10'h3AF, 10'h35B, 10'h36B, 10'h36D, 10'h357,
    10'h37B, 10'h37D, 10'h3B7, 10'h355, 10'h35D, 10'h3BB, 10'h2FB, 10'h37F,
    10'h001, 10'h1FF, 10'h15F, 10'h1F5, 10'h1DB, 10'h2D5, 10'h2BB, 10'h17F,
    10'h0FB, 10'h0F7, 10'h16F, 10'h1DF, 10'h075, 10'h035, 10'h057, 10'h1AF,
    10'h0B7, 10'h0BD, 10'h0ED, 10'h0FF, 10'h177, 10'h15B, 10'h16B, 10'h1AD,
    10'h1AB, 10'h1B7, 10'h0F5, 10'h1BD, 10'h1ED, 10'h055, 10'h1D7, 10'h2AF,
    10'h2BD, 10'h07D, 10'h0EB, 10'h0AD, 10'h0B5, 10'h077, 10'h0DB, 10'h0FD,
    10'h155, 10'h07F, 10'h1FD, 10'h17D, 10'h0D7, 10'h0BB, 10'h0DD, 10'h0AB,
    10'h0D5, 10'h1DD, 10'h0AF, 10'h06F, 10'h06D, 10'h157, 10'h1B5, 10'h15D,
    10'h175, 10'h17B, 10'h2AD, 10'h1F7, 10'h1EF, 10'h1FB, 10'h2BF, 10'h16D,
    10'h2DF, 10'h00B, 10'h05F, 10'h02F, 10'h02D, 10'h003, 10'h03D, 10'h05B,
    10'h02B, 10'h00D, 10'h1EB, 10'h0BF, 10'h01B, 10'h03B, 10'h00F, 10'h007,
    10'h03F, 10'h1BF, 10'h015, 10'h017, 10'h005, 10'h037, 10'h07B, 10'h06B,
    10'h0DF, 10'h05D, 10'h1D5, 10'h2B7, 10'h1BB, 10'h2B5, 10'h2D7, 10'h3B5
  };

  // Varicode word with its two separator zeros appended.
  function automatic logic [SegWidth-1:0] vari_seg(input logic [6:0] c);
    vari_seg = {VariTab[c], 2'b00};
  endfunction

  // Segment length: top set bit of the word plus one, plus the separator.
  function automatic logic [SegLenWidth-1:0] vari_len(input logic [6:0] c);
    logic [9:0] code;
    logic [SegLenWidth-1:0] len;
    code = VariTab[c];
    len  = '0;
    for (int i = 0; i < 10; i++) begin
      if (code[i]) len = SegLenWidth'(i + 1);
    end
    vari_len = len + SegLenWidth'(2);
  endfunction

endpackage

[rtl/core/psk31_varicode_byte_packer.sv]
// Top level of the PSK31 varicode byte packer.
// Input queue port: characters with an end-of-message flag are transferred when
// push is high and full is low. Result queue port: the oldest byte sits on out_o
// while empty is low and is transferred when pop is high.
// Config port: cfg_data_i (target burst length in bits) is written on any cycle
// with cfg_valid_i high; cfg_ready_o is tied high. Write it only while idle.
// The front end classifies each character into a command of bit segments and
// queues it (two entries). The back end packs segments into bytes, one byte a
// cycle through a single output register while the receiver keeps up.
// No byte of a burst reaches out_o before the second character is transferred.
// Throughput: at most one byte per cycle. The back end loads one
// segment a cycle (lead-in, held character, character, newline, fill, closing
// byte) and holds a load back while a whole byte would still be buffered.
// Reset clears all state but the queue memory; the target length resets to zero.
// When the receiver stalls the output register holds, the back end stops, the
// command queue fills and full rises; nothing is dropped.
module psk31_varicode_byte_packer #(
  parameter int unsigned BYTE_COUNT_BITS = pvbp_pkg::ByteCountBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  pvbp_pkg::in_item_t              in_i,
  input  logic                            pop,
  output logic                            empty,
  output pvbp_pkg::out_item_t             out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pvbp_pkg::MaxTxWidth-1:0] cfg_data_i
);

  pvbp_pkg::cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_full, cmd_vld, cmd_pop;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full;

  pvbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  pvbp_cmd_fifo #(
    .Depth (pvbp_pkg::CmdDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .vld_o  (cmd_vld),
    .data_o (cmd_head)
  );

  pvbp_back #(
    .ByteCountBits (BYTE_COUNT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_vld_i (cmd_vld),
    .cmd_i     (cmd_head),
    .cmd_pop_o (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_o     (out_o)
  );

endmodule

[rtl/core/pvbp_front.sv]
// Front end: accepts characters, tracks message state and issues segment commands.
module pvbp_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  input  pvbp_pkg::in_item_t                    in_i,
  input  logic                                  cfg_valid_i,
  input  logic [pvbp_pkg::MaxTxWidth-1:0]       cfg_data_i,
  input  logic                                  cmd_full_i,
  output logic                                  cmd_push_o,
  output pvbp_pkg::cmd_t                        cmd_o
);

  logic [pvbp_pkg::MaxTxWidth-1:0] max_tx_q;
  logic [6:0] held_q, held_d;
  logic [1:0] seen_q, seen_d;
  logic       closed_q, closed_d;
  logic       accept;
  logic       closed_mid;

  assign accept = push && !cmd_full_i;

  always_comb begin
    held_d     = held_q;
    seen_d     = seen_q;
    closed_d   = closed_q;
    closed_mid = closed_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.lim  = pvbp_pkg::PadWidth'({1'b0, max_tx_q[pvbp_pkg::MaxTxWidth-1:3]})
                 + pvbp_pkg::PadWidth'(1);
    cmd_o.close = in_i.end_of_message;
    // held character enters the stream when the second one arrives
    cmd_o.start  = (seen_q == 2'd1);
    cmd_o.c0_seg = pvbp_pkg::vari_seg(held_q);
    cmd_o.c0_len = pvbp_pkg::vari_len(held_q);
    if (seen_q == 2'd1) begin
      if (held_q == pvbp_pkg::NewlineChar) begin
        closed_mid = 1'b1;
      end else begin
        cmd_o.c0_vld = 1'b1;
      end
    end
    cmd_o.c1_seg = pvbp_pkg::vari_seg(in_i.character);
    cmd_o.c1_len = pvbp_pkg::vari_len(in_i.character);
    if (!closed_mid) begin
      if (in_i.character == pvbp_pkg::NewlineChar) begin
        closed_mid = 1'b1;
      end else begin
        cmd_o.c1_vld = 1'b1;
      end
    end
    if (accept) begin
      if (seen_q == 2'd0) begin
        if (in_i.end_of_message) begin
          seen_d   = 2'd0;
          closed_d = 1'b0;
        end else begin
          held_d = in_i.character;
          seen_d = 2'd1;
        end
      end else begin
        cmd_push_o = 1'b1;
        if (in_i.end_of_message) begin
          seen_d   = 2'd0;
          closed_d = 1'b0;
        end else begin
          seen_d   = 2'd2;
          closed_d = closed_mid;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tx_q <= '0;
      held_q   <= '0;
      seen_q   <= '0;
      closed_q <= 1'b0;
    end else begin
      if (cfg_valid_i) max_tx_q <= cfg_data_i;
      held_q   <= held_d;
      seen_q   <= seen_d;
      closed_q <= closed_d;
    end
  end

endmodule

[rtl/core/pvbp_cmd_fifo.sv]
// Short command queue between the front end and the byte packer.
module pvbp_cmd_fifo #(
  parameter int unsigned Depth = pvbp_pkg::CmdDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pvbp_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           vld_o,
  output pvbp_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pvbp_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign vld_o   = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/core/pvbp_back.sv]
// Back end: appends command segments to the bit buffer; up to one byte out per cycle.
module pvbp_back #(
  parameter int unsigned ByteCountBits = pvbp_pkg::ByteCountBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_vld_i,
  input  pvbp_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic                pop,
  output logic                empty,
  output pvbp_pkg::out_item_t out_o
);

  typedef enum logic [2:0] {
    PH_START, PH_C0, PH_C1, PH_NL, PH_FILL, PH_END
  } phase_e;

  localparam int unsigned WorkW = 19;
  localparam int unsigned CmpW  = 17;
  localparam logic [ByteCountBits-1:0] CntCap = '1;

  phase_e phase_q, phase_d, eff;
  logic   eff_vld, eff_last;

  logic [WorkW-1:0] work_q, work_d, rem_w;
  logic [4:0]       n_q, n_d, rem_n, sh;
  logic             end_ld_q, end_ld_d;
  logic [pvbp_pkg::PadWidth-1:0] lim_q, lim_d, pad;
  logic [ByteCountBits-1:0] cnt_q, cnt_d, cnt_inc;
  pvbp_pkg::out_item_t out_q, out_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free, emit, load;
  logic [pvbp_pkg::SegWidth-1:0]    seg;
  logic [pvbp_pkg::SegLenWidth-1:0] seg_len;
  logic   seg_end;
  logic [CmpW-1:0] cnt_ext, lim_ext;

  assign out_free = !out_vld_q || pop;
  assign emit     = (n_q >= 5'd8) && out_free;
  assign sh       = n_q - 5'd8;
  assign rem_n    = emit ? sh : n_q;
  assign rem_w    = emit ? (work_q & ((WorkW'(1) << sh) - WorkW'(1))) : work_q;
  assign load     = cmd_vld_i && (rem_n < 5'd8);

  assign cnt_inc  = (cnt_q == CntCap) ? cnt_q : cnt_q + ByteCountBits'(1);
  assign cnt_ext  = CmpW'(cnt_inc);
  assign lim_ext  = CmpW'(lim_q);
  assign pad      = (cnt_ext >= lim_ext) ? '0 : pvbp_pkg::PadWidth'(lim_ext - cnt_ext);

  // first enabled segment at or after the current phase
  always_comb begin
    eff      = phase_q;
    eff_vld  = 1'b1;
    eff_last = 1'b0;
    priority if (phase_q <= PH_START && cmd_i.start) begin
      eff      = PH_START;
      eff_last = !(cmd_i.c0_vld || cmd_i.c1_vld || cmd_i.close);
    end else if (phase_q <= PH_C0 && cmd_i.c0_vld) begin
      eff      = PH_C0;
      eff_last = !(cmd_i.c1_vld || cmd_i.close);
    end else if (phase_q <= PH_C1 && cmd_i.c1_vld) begin
      eff      = PH_C1;
      eff_last = !cmd_i.close;
    end else if (phase_q <= PH_NL && cmd_i.close) begin
      eff      = PH_NL;
    end else if (phase_q == PH_FILL) begin
      eff      = PH_FILL;
      eff_last = (rem_n == 5'd0);
    end else if (phase_q == PH_END) begin
      eff      = PH_END;
      eff_last = 1'b1;
    end else begin
      eff_vld  = 1'b0;
      eff_last = 1'b1;
    end
  end

  always_comb begin
    seg     = '0;
    seg_len = pvbp_pkg::SegLenWidth'(8);
    seg_end = 1'b0;
    unique case (eff)
      PH_START: ;
      PH_C0: begin
        seg     = cmd_i.c0_seg;
        seg_len = cmd_i.c0_len;
      end
      PH_C1: begin
        seg     = cmd_i.c1_seg;
        seg_len = cmd_i.c1_len;
      end
      PH_NL: begin
        seg     = pvbp_pkg::NewlineSeg;
        seg_len = pvbp_pkg::NewlineLen;
      end
      PH_FILL: begin
        // byte aligned already: go straight to the closing zero byte
        if (rem_n == 5'd0) begin
          seg_end = 1'b1;
        end else begin
          seg_len = pvbp_pkg::SegLenWidth'(5'd8 - rem_n);
        end
      end
      PH_END: seg_end = 1'b1;
      default: ;
    endcase
    if (!eff_vld) seg_len = '0;
  end

  always_comb begin
    work_d    = rem_w;
    n_d       = rem_n;
    phase_d   = phase_q;
    end_ld_d  = emit ? 1'b0 : end_ld_q;
    lim_d     = lim_q;
    cmd_pop_o = 1'b0;
    cnt_d     = cnt_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !pop;
    if (emit) begin
      out_d.byte_out    = ~8'(work_q >> sh);
      out_d.burst_start = (cnt_q == '0);
      out_d.burst_end   = end_ld_q;
      out_d.pad_bytes   = end_ld_q ? pad : '0;
      out_vld_d         = 1'b1;
      cnt_d             = end_ld_q ? '0 : cnt_inc;
    end
    if (load) begin
      work_d = WorkW'(rem_w << seg_len) | WorkW'(seg);
      n_d    = rem_n + 5'(seg_len);
      if (seg_end) begin
        end_ld_d = 1'b1;
        lim_d    = cmd_i.lim;
      end
      if (eff_last) begin
        cmd_pop_o = 1'b1;
        phase_d   = PH_START;
      end else begin
        unique case (eff)
          PH_START: phase_d = PH_C0;
          PH_C0:    phase_d = PH_C1;
          PH_C1:    phase_d = PH_NL;
          PH_NL:    phase_d = PH_FILL;
          PH_FILL:  phase_d = PH_END;
          PH_END:   phase_d = PH_START;
          default:  phase_d = PH_START;
        endcase
      end
    end
  end

  assign empty = !out_vld_q;
  assign out_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      work_q    <= '0;
      n_q       <= '0;
      end_ld_q  <= 1'b0;
      lim_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      work_q    <= work_d;
      n_q       <= n_d;
      end_ld_q  <= end_ld_d;
      lim_q     <= lim_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

endmodule

[rtl/core/pvbp_checker.sv]
// Port-level checks for the PSK31 varicode byte packer, bound to the top level.
module pvbp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                pop,
  input logic                empty,
  input pvbp_pkg::out_item_t out_o
);

  // a waiting result holds until it is transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("result changed before transfer");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result queue not empty after reset");

  a_pad_only_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_o.burst_end |-> out_o.pad_bytes == '0)
    else $error("pad count on a byte that does not end a burst");

  // a burst is always at least two bytes long
  a_start_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_o.burst_start && out_o.burst_end))
    else $error("byte both starts and ends a burst");

endmodule

bind psk31_varicode_byte_packer pvbp_checker u_pvbp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .pop    (pop),
  .empty  (empty),
  .out_o  (out_o)
);
